// File: rtl/core/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// shared types and constants of the rgb to hsv converter
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

    localparam int CHAN_W       = 8;
    localparam int BASE_W       = 12;
    localparam int HUE_W        = 15;
    localparam int SAT_SCALE    = 255;
    localparam int SECTOR_DEG   = 60;
    localparam int FULL_SECTORS = 6;
    localparam int RED_OFS      = 6;
    localparam int GREEN_OFS    = 8;
    localparam int BLUE_OFS     = 10;

    typedef logic [CHAN_W-1:0] chan_t;

    typedef struct packed {
        logic  defined;
        chan_t brightness;
    } rhc_side_t;

endpackage

`default_nettype wire

// File: rtl/core/rhc_front.sv
// ----------------------------------------------------------------------------
// rhc_front
// max/min search, sector offset and scaled dividends, two register stages
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_front #(
    parameter int HUE_FRACTION_BITS = 6,
    parameter int PW                = 24
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   adv,
    input  wire                   in_valid,
    input  rhc_pkg::chan_t        red,
    input  rhc_pkg::chan_t        green,
    input  rhc_pkg::chan_t        blue,
    output logic                  out_valid,
    output logic [PW-1:0]         h_num,
    output logic [PW-1:0]         s_num,
    output rhc_pkg::chan_t        h_div,
    output rhc_pkg::chan_t        s_div,
    output rhc_pkg::rhc_side_t    side
);
    import rhc_pkg::*;

    localparam int SECTOR_SCALE = SECTOR_DEG << HUE_FRACTION_BITS;

    chan_t              hi;
    chan_t              lo;
    chan_t              rg_max;
    chan_t              rg_min;
    logic [BASE_W-1:0]  base_next;

    logic               a_valid_reg;
    chan_t              a_hi_reg;
    chan_t              a_delta_reg;
    logic [BASE_W-1:0]  a_base_reg;

    logic               b_valid_reg;
    logic [PW-1:0]      b_h_num_reg;
    logic [PW-1:0]      b_s_num_reg;
    chan_t              b_hi_reg;
    chan_t              b_delta_reg;

    always_comb begin
        rg_max = (red > green) ? red : green;
        rg_min = (red < green) ? red : green;
        hi     = (rg_max > blue) ? rg_max : blue;
        lo     = (rg_min < blue) ? rg_min : blue;
        if (red == hi) begin
            base_next = BASE_W'(RED_OFS) * BASE_W'(hi - lo) + BASE_W'(green)
                        - BASE_W'(blue);
        end else if (green == hi) begin
            base_next = BASE_W'(GREEN_OFS) * BASE_W'(hi - lo) + BASE_W'(blue)
                        - BASE_W'(red);
        end else begin
            base_next = BASE_W'(BLUE_OFS) * BASE_W'(hi - lo) + BASE_W'(red)
                        - BASE_W'(green);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_hi_reg    <= hi;
            a_delta_reg <= hi - lo;
            a_base_reg  <= base_next;
            b_h_num_reg <= PW'(a_base_reg) * PW'(SECTOR_SCALE);
            b_s_num_reg <= PW'(a_delta_reg) * PW'(SAT_SCALE);
            b_hi_reg    <= a_hi_reg;
            b_delta_reg <= a_delta_reg;
        end
    end

    assign out_valid       = b_valid_reg;
    assign h_num           = b_h_num_reg;
    assign s_num           = b_s_num_reg;
    assign h_div           = b_delta_reg;
    assign s_div           = b_hi_reg;
    assign side.defined    = (b_delta_reg != '0);
    assign side.brightness = b_hi_reg;

endmodule

`default_nettype wire

// File: rtl/core/rhc_div_cell.sv
// ----------------------------------------------------------------------------
// rhc_div_cell
// one restoring division step for the hue and saturation lanes
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_div_cell #(
    parameter int QW = 16
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   adv,
    input  wire                   in_valid,
    input  rhc_pkg::chan_t        in_h_rem,
    input  wire [QW-1:0]          in_h_low,
    input  rhc_pkg::chan_t        in_h_div,
    input  rhc_pkg::chan_t        in_s_rem,
    input  wire [QW-1:0]          in_s_low,
    input  rhc_pkg::chan_t        in_s_div,
    input  rhc_pkg::rhc_side_t    in_side,
    output logic                  out_valid,
    output rhc_pkg::chan_t        out_h_rem,
    output logic [QW-1:0]         out_h_low,
    output rhc_pkg::chan_t        out_h_div,
    output rhc_pkg::chan_t        out_s_rem,
    output logic [QW-1:0]         out_s_low,
    output rhc_pkg::chan_t        out_s_div,
    output rhc_pkg::rhc_side_t    out_side
);
    import rhc_pkg::*;

    logic [CHAN_W:0] h_trial;
    logic [CHAN_W:0] s_trial;
    logic            h_bit;
    logic            s_bit;

    logic            valid_reg;
    chan_t           h_rem_reg;
    logic [QW-1:0]   h_low_reg;
    chan_t           h_div_reg;
    chan_t           s_rem_reg;
    logic [QW-1:0]   s_low_reg;
    chan_t           s_div_reg;
    rhc_side_t       side_reg;

    always_comb begin
        h_trial = {in_h_rem, in_h_low[QW-1]};
        s_trial = {in_s_rem, in_s_low[QW-1]};
        h_bit   = (h_trial >= {1'b0, in_h_div});
        s_bit   = (s_trial >= {1'b0, in_s_div});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            h_rem_reg <= h_bit ? CHAN_W'(h_trial - {1'b0, in_h_div}) : CHAN_W'(h_trial);
            s_rem_reg <= s_bit ? CHAN_W'(s_trial - {1'b0, in_s_div}) : CHAN_W'(s_trial);
            h_low_reg <= {in_h_low[QW-2:0], h_bit};
            s_low_reg <= {in_s_low[QW-2:0], s_bit};
            h_div_reg <= in_h_div;
            s_div_reg <= in_s_div;
            side_reg  <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_h_rem = h_rem_reg;
    assign out_h_low = h_low_reg;
    assign out_h_div = h_div_reg;
    assign out_s_rem = s_rem_reg;
    assign out_s_low = s_low_reg;
    assign out_s_div = s_div_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

// File: rtl/core/rgb_to_hsv_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// pipelined 8-bit rgb to fixed-point hsv conversion
// ----------------------------------------------------------------------------
// input request: s_tdata = red [7:0], green [15:8], blue [23:16]
// result request: m_tdata = hue [14:0], saturation [22:15], brightness [30:23],
//   bit 31 zero; m_tuser = hue_defined (0 for black or grey pixels, hue 0)
// hue is in units of 1/2^HUE_FRACTION_BITS degree
// the chain of QW divider cells, QW = max(16, 10 + HUE_FRACTION_BITS),
//   produces one quotient bit of hue and one of saturation per cell
// throughput is one pixel per cycle when the output does not stall
// the whole pipeline advances together; while m_tvalid is high and
//   m_tready low it freezes and s_tready drops, no request is lost
// aresetn clears all valid bits; the block takes requests right after
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_converter #(
    parameter int HUE_FRACTION_BITS = 6
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [23:0]  s_tdata,   // red, green, blue
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // hue, saturation, brightness, pad
    output logic        m_tuser    // hue_defined
);
    import rhc_pkg::*;

    localparam int QW        = (10 + HUE_FRACTION_BITS > 16) ? 10 + HUE_FRACTION_BITS : 16;
    localparam int PW        = QW + CHAN_W;
    localparam int FULL      = FULL_SECTORS * (SECTOR_DEG << HUE_FRACTION_BITS);
    localparam bit HUE_FITS  = (FULL <= (1 << HUE_W));

    logic adv;

    logic [PW-1:0] f_h_num;
    logic [PW-1:0] f_s_num;

    logic            c_valid [0:QW];
    chan_t           c_h_rem [0:QW];
    logic [QW-1:0]   c_h_low [0:QW];
    chan_t           c_h_div [0:QW];
    chan_t           c_s_rem [0:QW];
    logic [QW-1:0]   c_s_low [0:QW];
    chan_t           c_s_div [0:QW];
    rhc_side_t       c_side  [0:QW];

    logic [QW-1:0]   hue_wide;
    logic            o_valid_reg;
    logic [HUE_W-1:0] o_hue_reg;
    chan_t           o_sat_reg;
    chan_t           o_bright_reg;
    logic            o_defined_reg;

    assign adv      = !o_valid_reg || m_tready;
    assign s_tready = adv;

    rhc_front #(
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS),
        .PW                (PW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .red       (s_tdata[7:0]),
        .green     (s_tdata[15:8]),
        .blue      (s_tdata[23:16]),
        .out_valid (c_valid[0]),
        .h_num     (f_h_num),
        .s_num     (f_s_num),
        .h_div     (c_h_div[0]),
        .s_div     (c_s_div[0]),
        .side      (c_side[0])
    );

    assign c_h_rem[0] = f_h_num[PW-1:QW];
    assign c_h_low[0] = f_h_num[QW-1:0];
    assign c_s_rem[0] = f_s_num[PW-1:QW];
    assign c_s_low[0] = f_s_num[QW-1:0];

    for (genvar i = 0; i < QW; i++) begin : g_cell
        rhc_div_cell #(
            .QW (QW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (c_valid[i]),
            .in_h_rem  (c_h_rem[i]),
            .in_h_low  (c_h_low[i]),
            .in_h_div  (c_h_div[i]),
            .in_s_rem  (c_s_rem[i]),
            .in_s_low  (c_s_low[i]),
            .in_s_div  (c_s_div[i]),
            .in_side   (c_side[i]),
            .out_valid (c_valid[i+1]),
            .out_h_rem (c_h_rem[i+1]),
            .out_h_low (c_h_low[i+1]),
            .out_h_div (c_h_div[i+1]),
            .out_s_rem (c_s_rem[i+1]),
            .out_s_low (c_s_low[i+1]),
            .out_s_div (c_s_div[i+1]),
            .out_side  (c_side[i+1])
        );
    end

    // quotient carries a full turn of offset
    always_comb begin
        if (c_h_low[QW] >= QW'(FULL)) begin
            hue_wide = c_h_low[QW] - QW'(FULL);
        end else begin
            hue_wide = c_h_low[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (adv) begin
            o_valid_reg <= c_valid[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            o_defined_reg <= c_side[QW].defined;
            o_bright_reg  <= c_side[QW].brightness;
            o_hue_reg     <= c_side[QW].defined ? hue_wide[HUE_W-1:0] : '0;
            o_sat_reg     <= c_side[QW].defined ? c_s_low[QW][CHAN_W-1:0] : '0;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {1'b0, o_bright_reg, o_sat_reg, o_hue_reg};
    assign m_tuser  = o_defined_reg;

    a_undefined_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[14:0] == '0 && m_tdata[22:15] == '0)
        else $error("undefined hue with nonzero hue or saturation");

    a_defined_bright : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[30:23] != '0)
        else $error("defined hue on a black pixel");

    a_hue_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && HUE_FITS |-> 32'(m_tdata[14:0]) < 32'(FULL))
        else $error("hue beyond a full turn");

    a_stall_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(c_valid[QW]) && $stable(o_hue_reg) && $stable(c_h_low[QW]))
        else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

// File: tb/rgb_to_hsv_converter_tb.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_tb
// self-checking bench for the rgb to hsv converter: a queue-fed driver sends
// directed corner pixels, then random ones, with random idle bursts on both
// the request and result sides; each request's hsv result is predicted on
// acceptance and compared field by field, in order, with what comes back
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_converter_tb;

    import rhc_pkg::*;

    localparam int HUE_FRACTION_BITS = 6;
    localparam int RANDOM_PIXELS     = 450;
    localparam int CALM_TAIL         = 60;
    localparam int DRAIN_CYCLES      = 50;
    localparam int RUN_LIMIT         = 400000;

    localparam longint unsigned HUE_STEP = longint'(SECTOR_DEG) << HUE_FRACTION_BITS;
    localparam longint unsigned HUE_TURN = FULL_SECTORS * HUE_STEP;

    typedef struct {
        chan_t red;
        chan_t green;
        chan_t blue;
    } pixel_t;

    typedef struct {
        logic [HUE_W-1:0] hue;
        logic             defined;
        chan_t            sat;
        chan_t            bright;
    } hsv_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // red, green, blue
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // hue, saturation, brightness, pad
    logic        m_tuser;          // hue_defined

    pixel_t pix_pending_q[$];
    hsv_t   hsv_expected_q[$];
    int     pix_sent       = 0;
    int     mismatch_count = 0;
    int     src_gap        = 0;
    int     sink_gap       = 0;

    rgb_to_hsv_converter #(
        .HUE_FRACTION_BITS(HUE_FRACTION_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #2 aclk = ~aclk;

    function automatic hsv_t hsv_of(chan_t r, chan_t g, chan_t b);
        hsv_t              res;
        int unsigned       hi;
        int unsigned       lo;
        int unsigned       delta;
        longint unsigned   num;
        longint unsigned   q;
        hi = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        lo = r;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        delta = hi - lo;
        res.hue     = '0;
        res.defined = 1'b0;
        res.sat     = '0;
        res.bright  = chan_t'(hi);
        if (hi != 0)
            res.sat = chan_t'((delta * SAT_SCALE) / hi);
        if (delta != 0) begin
            // offset by a full turn so the numerator stays non-negative
            if (r == hi)
                num = longint'(RED_OFS * delta + g) - b;
            else if (g == hi)
                num = longint'(GREEN_OFS * delta + b) - r;
            else
                num = longint'(BLUE_OFS * delta + r) - g;
            q = (num * HUE_STEP) / delta;
            if (q >= HUE_TURN)
                q -= HUE_TURN;
            res.hue     = q[HUE_W-1:0];
            res.defined = 1'b1;
        end
        return res;
    endfunction

    // idling only in some stretches, and never near the end
    function automatic bit idle_allowed();
        return pix_pending_q.size() > CALM_TAIL && ((pix_sent >> 6) % 3) != 0;
    endfunction

    function automatic chan_t extreme_chan();
        case ($urandom_range(0, 2))
            0: return 8'h00;
            1: return 8'hff;
            default: return chan_t'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_pixel(chan_t r, chan_t g, chan_t b);
        pixel_t p;
        p.red   = r;
        p.green = g;
        p.blue  = b;
        pix_pending_q.push_back(p);
    endtask

    // request driver
    always @(posedge aclk) begin : drive
        logic        next_valid;
        logic [23:0] next_data;
        pixel_t      pix;
        next_valid = s_tvalid;
        next_data  = s_tdata;
        if (!aresetn) begin
            next_valid = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                hsv_expected_q.push_back(hsv_of(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]));
                next_valid = 1'b0;
            end
            if (!next_valid && pix_pending_q.size() != 0) begin
                if (src_gap != 0) begin
                    src_gap--;
                end else if (idle_allowed() && $urandom_range(0, 3) == 0) begin
                    src_gap = $urandom_range(0, 6);
                end else begin
                    pix        = pix_pending_q.pop_front();
                    next_valid = 1'b1;
                    next_data  = {pix.blue, pix.green, pix.red};
                    pix_sent++;
                end
            end
        end
        s_tvalid <= next_valid;
        s_tdata  <= next_data;
    end

    // result monitor and back-pressure
    always @(posedge aclk) begin : monitor
        hsv_t got;
        hsv_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.hue     = m_tdata[HUE_W-1:0];
                got.sat     = m_tdata[HUE_W+CHAN_W-1:HUE_W];
                got.bright  = m_tdata[HUE_W+2*CHAN_W-1:HUE_W+CHAN_W];
                got.defined = m_tuser;
                if (hsv_expected_q.size() == 0) begin
                    $display("%0t: unexpected result hue %0d sat %0d bright %0d defined %0b",
                             $time, got.hue, got.sat, got.bright, got.defined);
                    mismatch_count++;
                end else begin
                    want = hsv_expected_q.pop_front();
                    if (got.hue !== want.hue) begin
                        $display("%0t: hue expected %0d actual %0d", $time, want.hue, got.hue);
                        mismatch_count++;
                    end
                    if (got.defined !== want.defined) begin
                        $display("%0t: hue_defined expected %0b actual %0b",
                                 $time, want.defined, got.defined);
                        mismatch_count++;
                    end
                    if (got.sat !== want.sat) begin
                        $display("%0t: saturation expected %0d actual %0d",
                                 $time, want.sat, got.sat);
                        mismatch_count++;
                    end
                    if (got.bright !== want.bright) begin
                        $display("%0t: brightness expected %0d actual %0d",
                                 $time, want.bright, got.bright);
                        mismatch_count++;
                    end
                end
            end
            if (sink_gap != 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else if (idle_allowed() && $urandom_range(0, 3) == 0) begin
                sink_gap = $urandom_range(0, 6);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        chan_t v;
        // black, white and greys
        push_pixel(8'd0, 8'd0, 8'd0);
        push_pixel(8'd255, 8'd255, 8'd255);
        push_pixel(8'd1, 8'd1, 8'd1);
        push_pixel(8'd128, 8'd128, 8'd128);
        // primaries, smallest and largest
        push_pixel(8'd255, 8'd0, 8'd0);
        push_pixel(8'd0, 8'd255, 8'd0);
        push_pixel(8'd0, 8'd0, 8'd255);
        push_pixel(8'd1, 8'd0, 8'd0);
        push_pixel(8'd0, 8'd1, 8'd0);
        push_pixel(8'd0, 8'd0, 8'd1);
        // ties for the largest channel
        push_pixel(8'd255, 8'd255, 8'd0);
        push_pixel(8'd0, 8'd255, 8'd255);
        push_pixel(8'd255, 8'd0, 8'd255);
        push_pixel(8'd200, 8'd200, 8'd17);
        // red largest with a hue below zero wraps around
        push_pixel(8'd255, 8'd0, 8'd1);
        push_pixel(8'd255, 8'd254, 8'd255);
        // small deltas at high brightness
        push_pixel(8'd255, 8'd254, 8'd254);
        push_pixel(8'd254, 8'd255, 8'd254);
        push_pixel(8'd254, 8'd254, 8'd255);
        // sector boundaries and mixed colors
        push_pixel(8'd254, 8'd255, 8'd0);
        push_pixel(8'd10, 8'd20, 8'd255);
        push_pixel(8'd200, 8'd100, 8'd150);
        push_pixel(8'd85, 8'd170, 8'd255);
        push_pixel(8'd3, 8'd2, 8'd1);
        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            case ($urandom_range(0, 9))
                6, 7: push_pixel(extreme_chan(), extreme_chan(), extreme_chan());
                8: begin
                    v = chan_t'($urandom_range(0, 255));
                    push_pixel(v, v, v);
                end
                9: begin
                    v = chan_t'($urandom_range(0, 255));
                    push_pixel(v ^ chan_t'($urandom_range(0, 1)),
                               v ^ chan_t'($urandom_range(0, 1)),
                               v ^ chan_t'($urandom_range(0, 3)));
                end
                default: push_pixel(chan_t'($urandom_range(0, 255)),
                                    chan_t'($urandom_range(0, 255)),
                                    chan_t'($urandom_range(0, 255)));
            endcase
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        while (pix_pending_q.size() != 0 || s_tvalid) @(posedge aclk);
        while (hsv_expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT);
        $display("%0t: run limit reached", $time);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
